>>> rtl/core/gsfe_pkg.sv
package gsfe_pkg;

   // Default number of strategies held by the engine.
   localparam int NUM_STRATEGIES_DEF = 8;

   // Register port geometry: three 32-bit registers at byte addresses 0, 4 and 8.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Operation codes.
   localparam logic [2:0] OP_ADD         = 3'd0;
   localparam logic [2:0] OP_DELETE      = 3'd1;
   localparam logic [2:0] OP_MUTANT      = 3'd2;
   localparam logic [2:0] OP_HOMOG       = 3'd3;
   localparam logic [2:0] OP_LOAD_PAYOFF = 3'd4;
   localparam logic [2:0] OP_LOAD_POP    = 3'd5;
   localparam logic [2:0] OP_COMPUTE     = 3'd6;

   // Register indexes, taken from paddr[3:2].
   localparam logic [1:0] CSR_ALPHA       = 2'd0;
   localparam logic [1:0] CSR_STRENGTH    = 2'd1;
   localparam logic [1:0] CSR_MAX_MEMBERS = 2'd2;

   // Fixed point one in Q1.16 and the register reset values.
   localparam logic [16:0] ONE_Q16           = 17'd65536;
   localparam logic [16:0] ALPHA_RESET       = 17'd32768;
   localparam logic [16:0] STRENGTH_RESET    = 17'd0;
   localparam logic [15:0] MAX_MEMBERS_RESET = 16'd8;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [2:0]         first_index;
      logic [2:0]         second_index;
      logic               table_select;
      logic signed [31:0] payoff_value;
      logic [15:0]        population_count;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic               oversize;
      logic               monomorphic;
      logic signed [47:0] group_fitness;
      logic [15:0]        member_total;
   } rsp_type;

endpackage

>>> rtl/core/group_strategy_fitness_engine.sv
// Add, delete, homogeneous and the load operations end with a sweep of the member count memory
// for the monomorphic flag (mutant has one more count update before it).
// Compute sums the population counts, then for each strategy present walks its payoff row and runs
// up to three divisions and four multiplications; the bit-serial divider is 50 + log2(N) bits long.
// One request is worked at a time; the next one is taken while the last response waits.
// Reset (synchronous, active high) clears counts, population counts, fitness and registers.
module group_strategy_fitness_engine #(
   parameter int NUM_STRATEGIES = gsfe_pkg::NUM_STRATEGIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  gsfe_pkg::req_type                 req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output gsfe_pkg::rsp_type                 rsp_payload,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [gsfe_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [gsfe_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [gsfe_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import gsfe_pkg::*;

   // Widths derived from the number of strategies.
   localparam int IDX_W  = $clog2(NUM_STRATEGIES);
   localparam int CNT_W  = $clog2(NUM_STRATEGIES + 2);
   localparam int PAY_AW = $clog2(NUM_STRATEGIES * NUM_STRATEGIES);
   localparam int PSUM_W = 16 + IDX_W;
   localparam int PROD_W = 49;
   localparam int ACC_W  = PROD_W + IDX_W + 1;
   localparam int DVD_W  = ACC_W;
   localparam int DVS_W  = PSUM_W;
   localparam int DC_W   = $clog2(DVD_W + 1);
   localparam int MP_W   = 68;
   localparam int MB_W   = 17;
   localparam int MC_W   = $clog2(MB_W + 1);
   localparam int T_W    = 50;
   localparam int Y_W    = 50;
   localparam int FACC_W = 48 + IDX_W + 1;
   localparam int WIDE_W = 72;

   localparam logic signed [WIDE_W-1:0] MAX48 = {{(WIDE_W-47){1'b0}}, {47{1'b1}}};
   localparam logic signed [WIDE_W-1:0] MIN48 = {{(WIDE_W-47){1'b1}}, {47{1'b0}}};

   // Sequencer states.
   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_DISP  = 5'd1;
   localparam logic [4:0] S_UPD   = 5'd2;
   localparam logic [4:0] S_MUT1  = 5'd3;
   localparam logic [4:0] S_MUT2  = 5'd4;
   localparam logic [4:0] S_MONO  = 5'd5;
   localparam logic [4:0] S_FIN   = 5'd6;
   localparam logic [4:0] S_PSUM  = 5'd7;
   localparam logic [4:0] S_IRD   = 5'd8;
   localparam logic [4:0] S_ICHK  = 5'd9;
   localparam logic [4:0] S_JLOOP = 5'd10;
   localparam logic [4:0] S_D1    = 5'd11;
   localparam logic [4:0] S_M1    = 5'd12;
   localparam logic [4:0] S_T1    = 5'd13;
   localparam logic [4:0] S_D2    = 5'd14;
   localparam logic [4:0] S_M2    = 5'd15;
   localparam logic [4:0] S_T2    = 5'd16;
   localparam logic [4:0] S_D3    = 5'd17;
   localparam logic [4:0] S_M3    = 5'd18;
   localparam logic [4:0] S_Y     = 5'd19;
   localparam logic [4:0] S_M4    = 5'd20;
   localparam logic [4:0] S_ACC   = 5'd21;
   localparam logic [4:0] S_FIT   = 5'd22;
   localparam logic [4:0] S_DIVW  = 5'd23;
   localparam logic [4:0] S_MULW  = 5'd24;

   function automatic logic signed [47:0] sat48(input logic signed [WIDE_W-1:0] v);
      logic signed [47:0] r;
      if (v > MAX48) begin
         r = MAX48[47:0];
      end else if (v < MIN48) begin
         r = MIN48[47:0];
      end else begin
         r = v[47:0];
      end
      return r;
   endfunction

   // Division by 65536 that truncates toward zero.
   function automatic logic signed [MP_W-17:0] tr16(input logic signed [MP_W-1:0] p);
      logic signed [MP_W-1:0] q;
      q = p + (p[MP_W-1] ? MP_W'(65535) : MP_W'(0));
      return q[MP_W-1:16];
   endfunction

   function automatic logic [PAY_AW-1:0] pay_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
      return PAY_AW'(int'(row) * NUM_STRATEGIES + int'(col));
   endfunction

   // Memories.
   logic [15:0]        cnt_mem  [NUM_STRATEGIES];
   logic [15:0]        pop_mem  [NUM_STRATEGIES];
   logic signed [31:0] pin_mem  [NUM_STRATEGIES*NUM_STRATEGIES];
   logic signed [31:0] pout_mem [NUM_STRATEGIES*NUM_STRATEGIES];

   logic [15:0]        cnt_q_ff, pop_q_ff;
   logic               cnt_vq_ff, pop_vq_ff;
   logic signed [31:0] pin_q_ff, pout_q_ff;

   logic [IDX_W-1:0]   cnt_raddr, pop_raddr, cnt_waddr, pop_waddr;
   logic [PAY_AW-1:0]  pay_raddr, pay_waddr;
   logic               cnt_we, pop_we, pay_we;
   logic [15:0]        cnt_wdata, pop_wdata;

   // Registers.
   logic [4:0]  state_ff, state_in, ret_ff, ret_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] i_ff, i_in, ridx_ff, ridx_in;
   logic [2:0]  op_ff, op_in, a_ff, a_in, b_ff, b_in;
   logic        sel_ff, sel_in;
   logic signed [31:0] pv_ff, pv_in;
   logic [15:0] pc_ff, pc_in;
   logic [16:0] alpha_ff, alpha_in, wsel_ff, wsel_in;
   logic [15:0] maxm_ff, maxm_in, total_ff, total_in;
   logic signed [47:0] fit_ff, fit_in;
   logic        ok_ff, ok_in, mono_ff, mono_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic [NUM_STRATEGIES-1:0] cnt_vld_ff, cnt_vld_in, pop_vld_ff, pop_vld_in;
   logic [PSUM_W-1:0]   psum_ff, psum_in;
   logic signed [PSUM_W:0] outp_ff, outp_in;
   logic [15:0]         c_ff, c_in;
   logic signed [ACC_W-1:0]  sin_ff, sin_in, sout_ff, sout_in;
   logic signed [PROD_W-1:0] prin_ff, prin_in, prout_ff, prout_in;
   logic        prv_ff, prv_in;
   logic signed [T_W-1:0]    t_ff, t_in;
   logic signed [Y_W-1:0]    y_ff, y_in;
   logic signed [FACC_W-1:0] acc_ff, acc_in;
   logic [DVD_W-1:0] dv_num_ff, dv_num_in;
   logic [DVS_W-1:0] dv_den_ff, dv_den_in, dv_rem_ff, dv_rem_in;
   logic        dv_neg_ff, dv_neg_in;
   logic [DC_W-1:0] dv_cnt_ff, dv_cnt_in;
   logic signed [MP_W-1:0] mu_a_ff, mu_a_in, mu_p_ff, mu_p_in;
   logic [MB_W-1:0] mu_b_ff, mu_b_in;
   logic [MC_W-1:0] mu_cnt_ff, mu_cnt_in;

   // Derived values.
   logic [15:0] cnt_rd, pop_rd;
   logic [IDX_W-1:0] a_idx, b_idx;
   logic a_ok, b_ok;
   logic [16:0] alpha_c, w_c, one_minus_alpha, one_minus_w;
   logic signed [DVD_W:0] quo;
   logic csr_wr;

   assign cnt_rd = cnt_vq_ff ? cnt_q_ff : 16'd0;
   assign pop_rd = pop_vq_ff ? pop_q_ff : 16'd0;
   assign a_idx  = IDX_W'(a_ff);
   assign b_idx  = IDX_W'(b_ff);
   assign a_ok   = int'(a_ff) < NUM_STRATEGIES;
   assign b_ok   = int'(b_ff) < NUM_STRATEGIES;
   assign alpha_c = (alpha_ff > ONE_Q16) ? ONE_Q16 : alpha_ff;
   assign w_c     = (wsel_ff > ONE_Q16) ? ONE_Q16 : wsel_ff;
   assign one_minus_alpha = ONE_Q16 - alpha_c;
   assign one_minus_w     = ONE_Q16 - w_c;
   assign quo = dv_neg_ff ? -$signed({1'b0, dv_num_ff}) : $signed({1'b0, dv_num_ff});

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign pready      = 1'b1;
   assign csr_wr      = psel && penable && pwrite;

   always_comb begin
      case (paddr[3:2])
         CSR_ALPHA:       prdata = CSR_DATA_W'(alpha_ff);
         CSR_STRENGTH:    prdata = CSR_DATA_W'(wsel_ff);
         CSR_MAX_MEMBERS: prdata = CSR_DATA_W'(maxm_ff);
         default:         prdata = '0;
      endcase
   end

   always_comb begin
      logic [16:0]            rem_sh;
      logic                   qbit;
      logic signed [16:0]     nj;
      logic signed [16:0]     mj;
      logic                   dv_go;
      logic signed [DVD_W-1:0] dv_val;
      logic [DVS_W-1:0]       dv_div;
      logic                   mu_go;
      logic signed [MP_W-1:0] mu_aval;
      logic [MB_W-1:0]        mu_bval;
      logic [DVS_W:0]         rsh;

      rem_sh = '0;
      qbit = 1'b0;
      rsh = '0;
      nj = $signed({1'b0, cnt_rd}) - ((ridx_ff == i_ff) ? 17'sd1 : 17'sd0);
      mj = $signed({1'b0, pop_rd}) - $signed({1'b0, cnt_rd});
      dv_go = 1'b0;
      dv_val = '0;
      dv_div = '0;
      mu_go = 1'b0;
      mu_aval = '0;
      mu_bval = '0;

      state_in = state_ff;   ret_in = ret_ff;   k_in = k_ff;   i_in = i_ff;
      ridx_in = ridx_ff;
      op_in = op_ff;  a_in = a_ff;  b_in = b_ff;  sel_in = sel_ff;  pv_in = pv_ff;
      pc_in = pc_ff;
      alpha_in = alpha_ff;  wsel_in = wsel_ff;  maxm_in = maxm_ff;
      total_in = total_ff;  fit_in = fit_ff;  ok_in = ok_ff;  mono_in = mono_ff;
      rsp_valid_in = rsp_valid_ff;  rsp_in = rsp_ff;
      cnt_vld_in = cnt_vld_ff;  pop_vld_in = pop_vld_ff;
      psum_in = psum_ff;  outp_in = outp_ff;  c_in = c_ff;
      sin_in = sin_ff;  sout_in = sout_ff;
      prin_in = prin_ff;  prout_in = prout_ff;  prv_in = 1'b0;
      t_in = t_ff;  y_in = y_ff;  acc_in = acc_ff;
      dv_num_in = dv_num_ff;  dv_den_in = dv_den_ff;  dv_rem_in = dv_rem_ff;
      dv_neg_in = dv_neg_ff;  dv_cnt_in = dv_cnt_ff;
      mu_a_in = mu_a_ff;  mu_b_in = mu_b_ff;  mu_p_in = mu_p_ff;  mu_cnt_in = mu_cnt_ff;

      cnt_raddr = '0;  pop_raddr = '0;  pay_raddr = '0;
      cnt_we = 1'b0;  cnt_waddr = a_idx;  cnt_wdata = '0;
      pop_we = 1'b0;  pop_waddr = a_idx;  pop_wdata = pc_ff;
      pay_we = 1'b0;  pay_waddr = pay_addr(a_idx, b_idx);

      if (csr_wr) begin
         case (paddr[3:2])
            CSR_ALPHA:       alpha_in = pwdata[16:0];
            CSR_STRENGTH:    wsel_in  = pwdata[16:0];
            CSR_MAX_MEMBERS: maxm_in  = pwdata[15:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in  = req_payload.opcode;
               a_in   = req_payload.first_index;
               b_in   = req_payload.second_index;
               sel_in = req_payload.table_select;
               pv_in  = req_payload.payoff_value;
               pc_in  = req_payload.population_count;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            ok_in = 1'b1;
            mono_in = 1'b1;
            k_in = '0;
            state_in = S_MONO;
            case (op_ff)
               OP_ADD, OP_DELETE: begin
                  if (!a_ok) begin
                     ok_in = 1'b0;
                  end else begin
                     cnt_raddr = a_idx;
                     state_in = S_UPD;
                  end
               end
               OP_MUTANT: begin
                  if (!a_ok || !b_ok) begin
                     ok_in = 1'b0;
                  end else if (a_ff != b_ff) begin
                     cnt_raddr = b_idx;
                     state_in = S_MUT1;
                  end
               end
               OP_HOMOG: begin
                  if (!a_ok) begin
                     ok_in = 1'b0;
                  end else begin
                     // Clearing every valid bit and writing max_members to entry a makes the group homogeneous.
                     cnt_vld_in = '0;
                     cnt_we = 1'b1;
                     cnt_wdata = maxm_ff;
                     total_in = maxm_ff;
                  end
               end
               OP_LOAD_PAYOFF: begin
                  if (!a_ok || !b_ok) begin
                     ok_in = 1'b0;
                  end else begin
                     pay_we = 1'b1;
                  end
               end
               OP_LOAD_POP: begin
                  if (!a_ok) begin
                     ok_in = 1'b0;
                  end else begin
                     pop_we = 1'b1;
                  end
               end
               OP_COMPUTE: begin
                  if (total_ff == 16'd0) begin
                     fit_in = '0;
                  end else if (total_ff == 16'd1) begin
                     fit_in = 48'($signed({1'b0, one_minus_w}));
                  end else begin
                     psum_in = '0;
                     state_in = S_PSUM;
                  end
               end
               default: ok_in = 1'b0;
            endcase
         end
         S_UPD: begin
            state_in = S_MONO;
            if (op_ff == OP_ADD) begin
               cnt_we = 1'b1;
               cnt_wdata = (cnt_rd != 16'hFFFF) ? cnt_rd + 16'd1 : cnt_rd;
               if (total_ff != 16'hFFFF) begin
                  total_in = total_ff + 16'd1;
               end
            end else if (cnt_rd == 16'd0) begin
               ok_in = 1'b0;
            end else begin
               cnt_we = 1'b1;
               cnt_wdata = cnt_rd - 16'd1;
               if (total_ff != 16'd0) begin
                  total_in = total_ff - 16'd1;
               end
            end
         end
         S_MUT1: begin
            if (cnt_rd == 16'd0) begin
               ok_in = 1'b0;
               state_in = S_MONO;
            end else begin
               cnt_we = 1'b1;
               cnt_waddr = b_idx;
               cnt_wdata = cnt_rd - 16'd1;
               cnt_raddr = a_idx;
               state_in = S_MUT2;
            end
         end
         S_MUT2: begin
            cnt_we = 1'b1;
            cnt_wdata = (cnt_rd != 16'hFFFF) ? cnt_rd + 16'd1 : cnt_rd;
            state_in = S_MONO;
         end
         S_MONO: begin
            // Pipelined sweep: issue read k, check the entry read in the previous cycle.
            if (int'(k_ff) < NUM_STRATEGIES) begin
               cnt_raddr = IDX_W'(k_ff);
            end
            if (k_ff != '0) begin
               if (cnt_rd != 16'd0 && cnt_rd < total_ff) begin
                  mono_in = 1'b0;
               end
            end
            if (int'(k_ff) == NUM_STRATEGIES) begin
               state_in = S_FIN;
            end else begin
               k_in = k_ff + CNT_W'(1);
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in.ok = ok_ff;
               rsp_in.oversize = total_ff > maxm_ff;
               rsp_in.monomorphic = mono_ff;
               rsp_in.group_fitness = fit_ff;
               rsp_in.member_total = total_ff;
               state_in = S_IDLE;
            end
         end
         S_PSUM: begin
            if (int'(k_ff) < NUM_STRATEGIES) begin
               pop_raddr = IDX_W'(k_ff);
            end
            if (k_ff != '0) begin
               psum_in = psum_ff + PSUM_W'(pop_rd);
            end
            if (int'(k_ff) == NUM_STRATEGIES) begin
               outp_in = $signed({1'b0, psum_in}) - $signed((PSUM_W+1)'(total_ff));
               i_in = '0;
               acc_in = '0;
               state_in = S_IRD;
            end else begin
               k_in = k_ff + CNT_W'(1);
            end
         end
         S_IRD: begin
            cnt_raddr = i_ff;
            state_in = S_ICHK;
         end
         S_ICHK: begin
            c_in = cnt_rd;
            if (cnt_rd == 16'd0) begin
               if (int'(i_ff) == NUM_STRATEGIES - 1) begin
                  state_in = S_FIT;
               end else begin
                  i_in = i_ff + IDX_W'(1);
                  state_in = S_IRD;
               end
            end else begin
               k_in = '0;
               sin_in = '0;
               sout_in = '0;
               state_in = S_JLOOP;
            end
         end
         S_JLOOP: begin
            // Three-stage walk over row i: read, multiply, accumulate.
            if (int'(k_ff) < NUM_STRATEGIES) begin
               cnt_raddr = IDX_W'(k_ff);
               pop_raddr = IDX_W'(k_ff);
               pay_raddr = pay_addr(i_ff, IDX_W'(k_ff));
               ridx_in = IDX_W'(k_ff);
            end
            if (k_ff != '0 && int'(k_ff) <= NUM_STRATEGIES) begin
               prv_in = 1'b1;
               prin_in = pin_q_ff * nj;
               prout_in = pout_q_ff * mj;
            end
            if (prv_ff) begin
               sin_in = sin_ff + ACC_W'(prin_ff);
               sout_in = sout_ff + ACC_W'(prout_ff);
            end
            if (int'(k_ff) == NUM_STRATEGIES + 1) begin
               state_in = S_D1;
            end else begin
               k_in = k_ff + CNT_W'(1);
            end
         end
         S_D1: begin
            dv_go = 1'b1;
            dv_val = sin_ff;
            dv_div = DVS_W'(total_ff - 16'd1);
            ret_in = S_M1;
         end
         S_M1: begin
            mu_go = 1'b1;
            mu_aval = MP_W'(sat48(WIDE_W'(quo)));
            mu_bval = alpha_c;
            ret_in = S_T1;
         end
         S_T1: begin
            t_in = T_W'(tr16(mu_p_ff));
            state_in = (outp_ff > 0) ? S_D2 : S_D3;
         end
         S_D2: begin
            dv_go = 1'b1;
            dv_val = sout_ff;
            dv_div = DVS_W'(outp_ff);
            ret_in = S_M2;
         end
         S_M2: begin
            mu_go = 1'b1;
            mu_aval = MP_W'(sat48(WIDE_W'(quo)));
            mu_bval = one_minus_alpha;
            ret_in = S_T2;
         end
         S_T2: begin
            t_in = t_ff + T_W'(tr16(mu_p_ff));
            state_in = S_D3;
         end
         S_D3: begin
            dv_go = 1'b1;
            dv_val = DVD_W'(t_ff);
            dv_div = DVS_W'(total_ff - 16'd1);
            ret_in = S_M3;
         end
         S_M3: begin
            mu_go = 1'b1;
            mu_aval = MP_W'(sat48(WIDE_W'(quo)));
            mu_bval = w_c;
            ret_in = S_Y;
         end
         S_Y: begin
            y_in = Y_W'($signed({1'b0, one_minus_w})) + Y_W'(tr16(mu_p_ff));
            state_in = S_M4;
         end
         S_M4: begin
            mu_go = 1'b1;
            mu_aval = MP_W'(y_ff);
            mu_bval = {1'b0, c_ff};
            ret_in = S_ACC;
         end
         S_ACC: begin
            acc_in = acc_ff + FACC_W'(sat48(WIDE_W'(mu_p_ff)));
            if (int'(i_ff) == NUM_STRATEGIES - 1) begin
               state_in = S_FIT;
            end else begin
               i_in = i_ff + IDX_W'(1);
               state_in = S_IRD;
            end
         end
         S_FIT: begin
            fit_in = sat48(WIDE_W'(acc_ff));
            k_in = '0;
            state_in = S_MONO;
         end
         S_DIVW: begin
            // Restoring division, one quotient bit per cycle on the magnitude.
            rsh = {dv_rem_ff, dv_num_ff[DVD_W-1]};
            if (rsh >= {1'b0, dv_den_ff}) begin
               qbit = 1'b1;
               rsh = rsh - {1'b0, dv_den_ff};
            end
            dv_rem_in = rsh[DVS_W-1:0];
            dv_num_in = {dv_num_ff[DVD_W-2:0], qbit};
            dv_cnt_in = dv_cnt_ff - DC_W'(1);
            if (dv_cnt_ff == DC_W'(1)) begin
               state_in = ret_ff;
            end
         end
         S_MULW: begin
            // Shift-and-add multiplication by a 17-bit unsigned factor.
            mu_p_in = mu_p_ff + (mu_b_ff[0] ? mu_a_ff : MP_W'(0));
            mu_a_in = mu_a_ff <<< 1;
            mu_b_in = mu_b_ff >> 1;
            mu_cnt_in = mu_cnt_ff - MC_W'(1);
            if (mu_cnt_ff == MC_W'(1)) begin
               state_in = ret_ff;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (dv_go) begin
         dv_neg_in = dv_val[DVD_W-1];
         dv_num_in = dv_val[DVD_W-1] ? DVD_W'(-dv_val) : DVD_W'(dv_val);
         dv_den_in = dv_div;
         dv_rem_in = '0;
         dv_cnt_in = DC_W'(DVD_W);
         state_in = S_DIVW;
      end
      if (mu_go) begin
         mu_a_in = mu_aval;
         mu_b_in = mu_bval;
         mu_p_in = '0;
         mu_cnt_in = MC_W'(MB_W);
         state_in = S_MULW;
      end
      if (cnt_we) begin
         cnt_vld_in[cnt_waddr] = 1'b1;
      end
      if (pop_we) begin
         pop_vld_in[pop_waddr] = 1'b1;
      end
      rem_sh = {1'b0, rem_sh[15:0]};
   end

   // Memories with one registered read port each.
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_q_ff  <= cnt_mem[cnt_raddr];
      cnt_vq_ff <= cnt_vld_ff[cnt_raddr];
      if (pop_we) begin
         pop_mem[pop_waddr] <= pop_wdata;
      end
      pop_q_ff  <= pop_mem[pop_raddr];
      pop_vq_ff <= pop_vld_ff[pop_raddr];
      if (pay_we && !sel_ff) begin
         pin_mem[pay_waddr] <= pv_ff;
      end
      if (pay_we && sel_ff) begin
         pout_mem[pay_waddr] <= pv_ff;
      end
      pin_q_ff  <= pin_mem[pay_raddr];
      pout_q_ff <= pout_mem[pay_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         k_ff         <= '0;
         i_ff         <= '0;
         alpha_ff     <= ALPHA_RESET;
         wsel_ff      <= STRENGTH_RESET;
         maxm_ff      <= MAX_MEMBERS_RESET;
         total_ff     <= '0;
         fit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_vld_ff   <= '0;
         pop_vld_ff   <= '0;
         prv_ff       <= 1'b0;
         dv_cnt_ff    <= '0;
         mu_cnt_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         k_ff         <= k_in;
         i_ff         <= i_in;
         alpha_ff     <= alpha_in;
         wsel_ff      <= wsel_in;
         maxm_ff      <= maxm_in;
         total_ff     <= total_in;
         fit_ff       <= fit_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_vld_ff   <= cnt_vld_in;
         pop_vld_ff   <= pop_vld_in;
         prv_ff       <= prv_in;
         dv_cnt_ff    <= dv_cnt_in;
         mu_cnt_ff    <= mu_cnt_in;
      end
      ridx_ff   <= ridx_in;
      op_ff     <= op_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      sel_ff    <= sel_in;
      pv_ff     <= pv_in;
      pc_ff     <= pc_in;
      ok_ff     <= ok_in;
      mono_ff   <= mono_in;
      rsp_ff    <= rsp_in;
      psum_ff   <= psum_in;
      outp_ff   <= outp_in;
      c_ff      <= c_in;
      sin_ff    <= sin_in;
      sout_ff   <= sout_in;
      prin_ff   <= prin_in;
      prout_ff  <= prout_in;
      t_ff      <= t_in;
      y_ff      <= y_in;
      acc_ff    <= acc_in;
      dv_num_ff <= dv_num_in;
      dv_den_ff <= dv_den_in;
      dv_rem_ff <= dv_rem_in;
      dv_neg_ff <= dv_neg_in;
      mu_a_ff   <= mu_a_in;
      mu_b_ff   <= mu_b_in;
      mu_p_ff   <= mu_p_in;
   end

endmodule
